// ----- hw/rtl/eslc_pkg.sv -----
// ----------------------------------------------------------------------------
// eslc_pkg
// shared types, codes and sizes for the expert slot cache
// ----------------------------------------------------------------------------
`default_nettype none

package eslc_pkg;

    localparam int EXPERT_W        = 8;
    localparam int SLOT_FW         = 5;
    localparam int USE_W           = 64;
    localparam int CFG_EXP_W       = 9;
    localparam int CFG_SLT_W       = 6;
    localparam int CFG_DATA_W      = 9;
    localparam int CFG_INDEX_W     = 1;
    localparam int NUM_EXPERTS_DEF = 256;
    localparam int NUM_SLOTS_DEF   = 32;

    localparam logic [CFG_EXP_W-1:0] CFG_EXP_RST = 9'd256;
    localparam logic [CFG_SLT_W-1:0] CFG_SLT_RST = 6'd32;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_PIN,
        OP_BATCH,
        OP_NONE
    } t_opcode;

    typedef enum logic [2:0] {
        RS_HIT,
        RS_MISS,
        RS_DUP,
        RS_INVALID,
        RS_NO_SLOT,
        RS_PIN_DONE,
        RS_BATCH_DONE
    } t_res_status;

    typedef enum logic [1:0] {
        SS_EMPTY,
        SS_LOADING,
        SS_READY,
        SS_FAILED
    } t_slot_st;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXPERTS_IN_USE,
        CFG_SLOTS_IN_USE
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_MAP_WAIT,
        ST_SLOT_WAIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_EVMAP,
        ST_COMMIT,
        ST_BAT_RD,
        ST_BAT_CHK,
        ST_BAT_MAP,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_opcode               opcode;
        logic [EXPERT_W-1:0]   expert;
        logic                  pin_value;
        logic                  load_failed;
    } t_in_item;

    typedef struct packed {
        t_res_status           status;
        logic [SLOT_FW-1:0]    slot;
        logic [EXPERT_W-1:0]   evicted_expert;
        logic                  evicted_valid;
    } t_out_item;

    typedef struct packed {
        logic [EXPERT_W-1:0]   owner;
        t_slot_st              status;
        logic                  pinned;
        logic                  reserved;
        logic [USE_W-1:0]      stamp;
    } t_slot_word;

    typedef struct packed {
        logic                  owner;
        logic                  status;
        logic                  pinned;
        logic                  reserved;
        logic                  stamp;
    } t_slot_we;

    typedef struct packed {
        logic                  found;
        logic                  ready;
        logic [EXPERT_W-1:0]   owner;
    } t_vic_info;

endpackage

`default_nettype wire

// ----- hw/rtl/eslc_map_ram.sv -----
// ----------------------------------------------------------------------------
// eslc_map_ram
// expert map memory: slot index, map valid and pin request per expert
// ----------------------------------------------------------------------------
`default_nettype none

module eslc_map_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/eslc_slot_ram.sv -----
// ----------------------------------------------------------------------------
// eslc_slot_ram
// per-slot state memory with a write enable for each field
// ----------------------------------------------------------------------------
`default_nettype none

module eslc_slot_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                  i_clk,
    input  eslc_pkg::t_slot_we    i_we,
    input  logic [AW-1:0]         i_waddr,
    input  eslc_pkg::t_slot_word  i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output eslc_pkg::t_slot_word  o_rdata
);

    import eslc_pkg::*;

    logic [EXPERT_W-1:0] r_owner    [DEPTH];
    t_slot_st            r_status   [DEPTH];
    logic                r_pinned   [DEPTH];
    logic                r_reserved [DEPTH];
    logic [USE_W-1:0]    r_stamp    [DEPTH];
    t_slot_word          r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we.owner) begin
            r_owner[i_waddr] <= i_wdata.owner;
        end
        if (i_we.status) begin
            r_status[i_waddr] <= i_wdata.status;
        end
        if (i_we.pinned) begin
            r_pinned[i_waddr] <= i_wdata.pinned;
        end
        if (i_we.reserved) begin
            r_reserved[i_waddr] <= i_wdata.reserved;
        end
        if (i_we.stamp) begin
            r_stamp[i_waddr] <= i_wdata.stamp;
        end
        r_rdata.owner    <= r_owner[i_raddr];
        r_rdata.status   <= r_status[i_raddr];
        r_rdata.pinned   <= r_pinned[i_raddr];
        r_rdata.reserved <= r_reserved[i_raddr];
        r_rdata.stamp    <= r_stamp[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/eslc_victim.sv -----
// ----------------------------------------------------------------------------
// eslc_victim
// victim selection unit: one slot word per cycle, first free slot or oldest
// ----------------------------------------------------------------------------
`default_nettype none

module eslc_victim #(
    parameter int SW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_valid,
    input  logic [SW-1:0]         i_idx,
    input  eslc_pkg::t_slot_word  i_word,
    output eslc_pkg::t_vic_info   o_info,
    output logic [SW-1:0]         o_idx
);

    import eslc_pkg::*;

    logic                r_any;
    logic                r_free;
    logic                r_ready;
    logic [USE_W-1:0]    r_oldest;
    logic [SW-1:0]       r_idx;
    logic [EXPERT_W-1:0] r_owner;
    logic                w_skip;
    logic                w_is_free;
    logic                w_take_free;
    logic                w_take_old;

    assign w_skip      = i_word.reserved || i_word.pinned || (i_word.status == SS_LOADING);
    assign w_is_free   = (i_word.status == SS_EMPTY) || (i_word.status == SS_FAILED);
    assign w_take_free = i_valid && !w_skip && !r_free && w_is_free;
    assign w_take_old  = i_valid && !w_skip && !r_free && !w_is_free &&
                         (i_word.stamp < r_oldest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_clear) begin
            r_any  <= 1'b0;
            r_free <= 1'b0;
        end else if (w_take_free) begin
            r_any  <= 1'b1;
            r_free <= 1'b1;
        end else if (w_take_old) begin
            r_any  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_oldest <= '1;
        end else if (w_take_free || w_take_old) begin
            r_oldest <= i_word.stamp;
            r_idx    <= i_idx;
            r_owner  <= i_word.owner;
            r_ready  <= w_take_old;
        end
    end

    assign o_info.found = r_any;
    assign o_info.ready = r_any && r_ready;
    assign o_info.owner = r_owner;
    assign o_idx        = r_idx;

endmodule

`default_nettype wire

// ----- hw/rtl/expert_slot_lru_cache_top.sv -----
// ----------------------------------------------------------------------------
// expert_slot_lru_cache_top
// expert to slot cache with lru replacement, pinning and batch reservations
//
// one item at a time; input stall is high from accept until the result is
// loaded into the output register. after reset a clearing pass over
// max(NUM_EXPERTS, NUM_SLOTS) entries runs before the first item is taken. an
// invalid expert goes straight to the response state, a pin command reads
// its map entry and a hit also reads the mapped slot. a miss runs the victim
// scan over slots_in_use slots, reading one slot per cycle through the single
// slot memory port, after the mapped slot read when one was made, and evicts a
// ready expert in its own map state before the commit; a scan that finds no
// slot skips the commit state, and with no slot in use the scan reads no slot.
// end batch reads and checks every slot in turn, with an extra map state per
// failed loading slot. a stalled output holds the result in the response state.
// ----------------------------------------------------------------------------
`default_nettype none

module expert_slot_lru_cache_top #(
    parameter int NUM_EXPERTS = eslc_pkg::NUM_EXPERTS_DEF,
    parameter int NUM_SLOTS   = eslc_pkg::NUM_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  eslc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output eslc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [eslc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [eslc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import eslc_pkg::*;

    localparam int EW    = $clog2(NUM_EXPERTS);
    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SCW   = $clog2(NUM_SLOTS + 1);
    localparam int CLN   = (NUM_EXPERTS > NUM_SLOTS) ? NUM_EXPERTS : NUM_SLOTS;
    localparam int CLW   = $clog2(CLN + 1);
    localparam int MDW   = SW + 2;
    localparam int M_PIN = MDW - 1;
    localparam int M_VLD = MDW - 2;

    t_state              r_state, n_state;
    t_in_item            r_item;
    logic [CFG_EXP_W-1:0] r_cfg_exp;
    logic [CFG_SLT_W-1:0] r_cfg_slt;
    logic [CLW-1:0]      r_clr, n_clr;
    logic [SCW-1:0]      r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [SW-1:0]       r_pidx, n_pidx;
    logic [MDW-1:0]      r_map_e, n_map_e;
    logic [EXPERT_W-1:0] r_own, n_own;
    logic [USE_W-1:0]    r_use, n_use;
    t_out_item           r_res, n_res;
    t_out_item           r_out;
    logic                r_out_valid;

    logic                w_map_we;
    logic [EW-1:0]       w_map_waddr;
    logic [MDW-1:0]      w_map_wdata;
    logic [EW-1:0]       w_map_raddr;
    logic [MDW-1:0]      w_map_rdata;
    t_slot_we            w_slot_we;
    logic [SW-1:0]       w_slot_waddr;
    t_slot_word          w_slot_wdata;
    logic [SW-1:0]       w_slot_raddr;
    t_slot_word          w_slot_rdata;
    logic                w_vic_clear;
    logic                w_vic_valid;
    t_vic_info           w_vic_info;
    logic [SW-1:0]       w_vic_idx;
    logic [SCW-1:0]      w_live;
    logic                w_exp_ok;
    logic                w_out_load;

    function automatic t_out_item f_res(t_res_status st, logic [SLOT_FW-1:0] sl,
                                        logic [EXPERT_W-1:0] ev, logic evv);
        t_out_item res;
        res.status         = st;
        res.slot           = sl;
        res.evicted_expert = ev;
        res.evicted_valid  = evv;
        return res;
    endfunction

    eslc_map_ram #(
        .DEPTH (NUM_EXPERTS),
        .AW    (EW),
        .DW    (MDW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_raddr (w_map_raddr),
        .o_rdata (w_map_rdata)
    );

    eslc_slot_ram #(
        .DEPTH (NUM_SLOTS),
        .AW    (SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    eslc_victim #(
        .SW (SW)
    ) u_victim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_vic_clear),
        .i_valid (w_vic_valid),
        .i_idx   (r_pidx),
        .i_word  (w_slot_rdata),
        .o_info  (w_vic_info),
        .o_idx   (w_vic_idx)
    );

    // effective register values
    always_comb begin
        if (int'(r_cfg_slt) > NUM_SLOTS) begin
            w_live = SCW'(NUM_SLOTS);
        end else begin
            w_live = SCW'(r_cfg_slt);
        end
    end

    assign w_exp_ok = (CFG_EXP_W'(i_in_item.expert) < r_cfg_exp) &&
                      (int'(i_in_item.expert) < NUM_EXPERTS);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_pidx       = r_pidx;
        n_map_e      = r_map_e;
        n_own        = r_own;
        n_use        = r_use;
        n_res        = r_res;
        w_map_we     = 1'b0;
        w_map_waddr  = EW'(r_item.expert);
        w_map_wdata  = '0;
        w_map_raddr  = EW'(r_item.expert);
        w_slot_we    = '0;
        w_slot_waddr = '0;
        w_slot_wdata = '0;
        w_slot_raddr = '0;
        w_vic_clear  = 1'b0;
        w_vic_valid  = 1'b0;
        o_in_stall   = 1'b1;

        unique case (r_state)
            ST_CLR: begin
                w_map_we     = (int'(r_clr) < NUM_EXPERTS);
                w_map_waddr  = r_clr[EW-1:0];
                w_slot_waddr = r_clr[SW-1:0];
                if (int'(r_clr) < NUM_SLOTS) begin
                    w_slot_we.status   = 1'b1;
                    w_slot_we.pinned   = 1'b1;
                    w_slot_we.reserved = 1'b1;
                    w_slot_we.stamp    = 1'b1;
                end
                if (r_clr == CLW'(CLN - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            ST_IDLE: begin
                o_in_stall  = 1'b0;
                w_map_raddr = EW'(i_in_item.expert);
                if (i_in_valid) begin
                    unique case (i_in_item.opcode) inside
                        OP_BATCH: begin
                            n_idx   = '0;
                            n_state = ST_BAT_RD;
                        end
                        OP_NONE: begin
                            n_state = ST_IDLE;
                        end
                        OP_LOOKUP, OP_PIN: begin
                            if (!w_exp_ok) begin
                                n_res   = f_res(RS_INVALID, '0, '0, 1'b0);
                                n_state = ST_RESP;
                            end else begin
                                n_state = ST_MAP_WAIT;
                            end
                        end
                    endcase
                end
            end

            ST_MAP_WAIT: begin
                n_map_e = w_map_rdata;
                if (r_item.opcode == OP_PIN) begin
                    w_map_we    = 1'b1;
                    w_map_wdata = {r_item.pin_value, w_map_rdata[M_VLD], w_map_rdata[SW-1:0]};
                    if (w_map_rdata[M_VLD]) begin
                        w_slot_we.pinned    = 1'b1;
                        w_slot_waddr        = w_map_rdata[SW-1:0];
                        w_slot_wdata.pinned = r_item.pin_value;
                    end
                    n_res   = f_res(RS_PIN_DONE, '0, '0, 1'b0);
                    n_state = ST_RESP;
                end else if (w_map_rdata[M_VLD] && (SCW'(w_map_rdata[SW-1:0]) < w_live)) begin
                    w_slot_raddr = w_map_rdata[SW-1:0];
                    n_state      = ST_SLOT_WAIT;
                end else begin
                    w_vic_clear = 1'b1;
                    n_idx       = '0;
                    n_state     = ST_SCAN;
                end
            end

            ST_SLOT_WAIT: begin
                if (w_slot_rdata.reserved) begin
                    n_res   = f_res(RS_DUP, SLOT_FW'(r_map_e[SW-1:0]), '0, 1'b0);
                    n_state = ST_RESP;
                end else if (w_slot_rdata.status == SS_READY) begin
                    w_slot_we.stamp       = 1'b1;
                    w_slot_we.reserved    = 1'b1;
                    w_slot_waddr          = r_map_e[SW-1:0];
                    w_slot_wdata.stamp    = r_use + 1'b1;
                    w_slot_wdata.reserved = 1'b1;
                    n_use                 = r_use + 1'b1;
                    n_res   = f_res(RS_HIT, SLOT_FW'(r_map_e[SW-1:0]), '0, 1'b0);
                    n_state = ST_RESP;
                end else begin
                    w_vic_clear = 1'b1;
                    n_idx       = '0;
                    n_state     = ST_SCAN;
                end
            end

            ST_SCAN: begin
                w_vic_valid = r_pend;
                if (r_idx < w_live) begin
                    w_slot_raddr = r_idx[SW-1:0];
                    n_pend       = 1'b1;
                    n_pidx       = r_idx[SW-1:0];
                    n_idx        = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_state = ST_SCAN_END;
                end
            end

            ST_SCAN_END: begin
                if (!w_vic_info.found) begin
                    n_res   = f_res(RS_NO_SLOT, '0, '0, 1'b0);
                    n_state = ST_RESP;
                end else if (w_vic_info.ready) begin
                    w_map_raddr = EW'(w_vic_info.owner);
                    n_state     = ST_EVMAP;
                end else begin
                    n_state = ST_COMMIT;
                end
            end

            ST_EVMAP: begin
                // unmap the old owner only if it still points at the victim
                if ((int'(w_vic_info.owner) < NUM_EXPERTS) && w_map_rdata[M_VLD] &&
                    (w_map_rdata[SW-1:0] == w_vic_idx)) begin
                    w_map_we    = 1'b1;
                    w_map_waddr = EW'(w_vic_info.owner);
                    w_map_wdata = {w_map_rdata[M_PIN], 1'b0, w_map_rdata[SW-1:0]};
                end
                n_state = ST_COMMIT;
            end

            ST_COMMIT: begin
                w_slot_we             = '1;
                w_slot_waddr          = w_vic_idx;
                w_slot_wdata.owner    = r_item.expert;
                w_slot_wdata.status   = SS_LOADING;
                w_slot_wdata.pinned   = r_map_e[M_PIN];
                w_slot_wdata.reserved = 1'b1;
                w_slot_wdata.stamp    = r_use + 1'b1;
                n_use                 = r_use + 1'b1;
                w_map_we              = 1'b1;
                w_map_wdata           = {r_map_e[M_PIN], 1'b1, w_vic_idx};
                n_res   = f_res(RS_MISS, SLOT_FW'(w_vic_idx),
                                w_vic_info.ready ? w_vic_info.owner : '0,
                                w_vic_info.ready);
                n_state = ST_RESP;
            end

            ST_BAT_RD: begin
                w_slot_raddr = r_idx[SW-1:0];
                n_state      = ST_BAT_CHK;
            end

            ST_BAT_CHK: begin
                w_slot_we.reserved    = 1'b1;
                w_slot_waddr          = r_idx[SW-1:0];
                w_slot_wdata.reserved = 1'b0;
                w_slot_wdata.status   = r_item.load_failed ? SS_FAILED : SS_READY;
                if (w_slot_rdata.status == SS_LOADING) begin
                    w_slot_we.status = 1'b1;
                end
                if ((w_slot_rdata.status == SS_LOADING) && r_item.load_failed) begin
                    n_own       = w_slot_rdata.owner;
                    w_map_raddr = EW'(w_slot_rdata.owner);
                    n_state     = ST_BAT_MAP;
                end else if (r_idx == SCW'(NUM_SLOTS - 1)) begin
                    n_res   = f_res(RS_BATCH_DONE, '0, '0, 1'b0);
                    n_state = ST_RESP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_BAT_RD;
                end
            end

            ST_BAT_MAP: begin
                if ((int'(r_own) < NUM_EXPERTS) && w_map_rdata[M_VLD] &&
                    (w_map_rdata[SW-1:0] == r_idx[SW-1:0])) begin
                    w_map_we    = 1'b1;
                    w_map_waddr = EW'(r_own);
                    w_map_wdata = {w_map_rdata[M_PIN], 1'b0, w_map_rdata[SW-1:0]};
                end
                if (r_idx == SCW'(NUM_SLOTS - 1)) begin
                    n_res   = f_res(RS_BATCH_DONE, '0, '0, 1'b0);
                    n_state = ST_RESP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_BAT_RD;
                end
            end

            ST_RESP: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    assign w_out_load = (r_state == ST_RESP) && !(r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_use       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_use   <= n_use;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_exp <= CFG_EXP_RST;
            r_cfg_slt <= CFG_SLT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_EXPERTS_IN_USE: r_cfg_exp <= i_cfg_data[CFG_EXP_W-1:0];
                CFG_SLOTS_IN_USE:   r_cfg_slt <= i_cfg_data[CFG_SLT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_item <= i_in_item;
        end
        r_pidx  <= n_pidx;
        r_map_e <= n_map_e;
        r_own   <= n_own;
        r_res   <= n_res;
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ----- bench/expert_slot_lru_cache_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expert_slot_lru_cache_top_tb
// self-checking bench for the expert slot cache
//
// a tracker class keeps its own copy of the slot table, the expert map, pin
// requests and the use counter, predicts the result of every accepted item and
// checks results in order. stimulus is a directed opening followed by random
// runs of mixed items under several register settings, including out-of-range ones,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------

module expert_slot_lru_cache_top_tb;

    import eslc_pkg::*;

    class cache_tracker;
        logic [EXPERT_W-1:0] owner[NUM_SLOTS_DEF];
        t_slot_st            sstat[NUM_SLOTS_DEF];
        logic [USE_W-1:0]    stamp[NUM_SLOTS_DEF];
        bit                  pinned[NUM_SLOTS_DEF];
        bit                  reserved[NUM_SLOTS_DEF];
        logic [5:0]          emap[NUM_EXPERTS_DEF];
        bit                  mapped[NUM_EXPERTS_DEF];
        bit                  pin_req[NUM_EXPERTS_DEF];
        logic [USE_W-1:0]    use_ctr;
        logic [CFG_EXP_W-1:0] cfg_experts;
        logic [CFG_SLT_W-1:0] cfg_slots;
        t_out_item           awaited[$];
        int                  errors;
        int                  checked;
        int                  status_seen[7];

        function new();
            int i;
            for (i = 0; i < NUM_SLOTS_DEF; i++) begin
                owner[i]    = '0;
                sstat[i]    = SS_EMPTY;
                stamp[i]    = '0;
                pinned[i]   = 0;
                reserved[i] = 0;
            end
            for (i = 0; i < NUM_EXPERTS_DEF; i++) begin
                emap[i]    = '0;
                mapped[i]  = 0;
                pin_req[i] = 0;
            end
            for (i = 0; i < 7; i++) status_seen[i] = 0;
            use_ctr     = '0;
            cfg_experts = CFG_EXP_RST;
            cfg_slots   = CFG_SLT_RST;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_EXPERTS_IN_USE) cfg_experts = val[CFG_EXP_W-1:0];
            else cfg_slots = val[CFG_SLT_W-1:0];
        endfunction

        function int pick_victim_slot(int n);
            int s;
            int best;
            logic [USE_W-1:0] oldest;
            best   = -1;
            oldest = '1;
            for (s = 0; s < n; s++) begin
                if (reserved[s] || pinned[s] || sstat[s] == SS_LOADING) continue;
                if (sstat[s] == SS_EMPTY || sstat[s] == SS_FAILED) return s;
                if (stamp[s] < oldest) begin
                    oldest = stamp[s];
                    best   = s;
                end
            end
            return best;
        endfunction

        function t_out_item predict_lookup(logic [EXPERT_W-1:0] e, int n_slt);
            t_out_item r;
            int s;
            int v;
            logic [EXPERT_W-1:0] o;
            r = '0;
            if (mapped[e] && int'(emap[e]) < n_slt) begin
                s = emap[e];
                if (reserved[s]) begin
                    r.status = RS_DUP;
                    r.slot   = 5'(s);
                    return r;
                end
                if (sstat[s] == SS_READY) begin
                    use_ctr     = use_ctr + 1;
                    stamp[s]    = use_ctr;
                    reserved[s] = 1;
                    r.status    = RS_HIT;
                    r.slot      = 5'(s);
                    return r;
                end
            end
            v = pick_victim_slot(n_slt);
            if (v < 0) begin
                r.status = RS_NO_SLOT;
                return r;
            end
            if (sstat[v] == SS_READY) begin
                o                = owner[v];
                r.evicted_expert = o;
                r.evicted_valid  = 1'b1;
                if (mapped[o] && int'(emap[o]) == v) mapped[o] = 0;
            end
            owner[v]    = e;
            pinned[v]   = pin_req[e];
            sstat[v]    = SS_LOADING;
            use_ctr     = use_ctr + 1;
            stamp[v]    = use_ctr;
            reserved[v] = 1;
            emap[e]     = 6'(v);
            mapped[e]   = 1;
            r.status    = RS_MISS;
            r.slot      = 5'(v);
            return r;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            int n_exp;
            int n_slt;
            int s;
            logic [EXPERT_W-1:0] o;
            r     = '0;
            n_exp = (cfg_experts > NUM_EXPERTS_DEF) ? NUM_EXPERTS_DEF : int'(cfg_experts);
            n_slt = (cfg_slots > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : int'(cfg_slots);
            if (it.opcode == OP_NONE) return;
            if (it.opcode == OP_BATCH) begin
                for (s = 0; s < NUM_SLOTS_DEF; s++) begin
                    if (sstat[s] == SS_LOADING) begin
                        if (!it.load_failed) begin
                            sstat[s] = SS_READY;
                        end else begin
                            o        = owner[s];
                            sstat[s] = SS_FAILED;
                            if (mapped[o] && int'(emap[o]) == s) mapped[o] = 0;
                        end
                    end
                    reserved[s] = 0;
                end
                r.status = RS_BATCH_DONE;
            end else if (int'(it.expert) >= n_exp) begin
                r.status = RS_INVALID;
            end else if (it.opcode == OP_PIN) begin
                pin_req[it.expert] = it.pin_value;
                if (mapped[it.expert]) pinned[emap[it.expert]] = it.pin_value;
                r.status = RS_PIN_DONE;
            end else begin
                r = predict_lookup(it.expert, n_slt);
            end
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            checked++;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result error: unexpected item status %0d slot %0d",
                             got.status, got.slot);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.evicted_expert !== want.evicted_expert ||
                got.evicted_valid !== want.evicted_valid) begin
                errors++;
                if (errors <= 10) begin
                    $write("result error %0d: status %0d/%0d slot %0d/%0d ",
                           checked, want.status, got.status, want.slot, got.slot);
                    $display("evicted %0d/%0d evicted_valid %0d/%0d (want/got)",
                             want.evicted_expert, got.evicted_expert,
                             want.evicted_valid, got.evicted_valid);
                end
            end else begin
                status_seen[int'(got.status)]++;
            end
        endfunction
    endclass

    localparam int HOLD_OFF   = 120;
    localparam int IDLE_LIMIT = 5000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_item = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    cache_tracker tracker;
    bit           no_idle = 0;
    int           rcv_wait = 0;
    int           quiet_cycles = 0;
    int           items_sent = 0;
    int           configs = 0;
    int           cur_exp = 256;
    int           cur_slt = 32;

    expert_slot_lru_cache_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: check at the edge, then draw the stall for the next item
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            tracker.check_result(o_out_item);
            rcv_wait = no_idle ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge i_clk) begin
        if (rcv_wait > 0) begin
            i_out_stall <= 1'b1;
            rcv_wait = rcv_wait - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("expert_slot_lru_cache_top: mismatch");
            $finish;
        end
    end

    function automatic t_in_item mk(t_opcode op, int e, bit pv, bit lf);
        t_in_item it;
        it.opcode      = op;
        it.expert      = 8'(e);
        it.pin_value   = pv;
        it.load_failed = lf;
        return it;
    endfunction

    function automatic t_in_item rand_item(int pool);
        t_in_item it;
        int r;
        r              = $urandom_range(0, 99);
        it.pin_value   = 1'($urandom_range(0, 1));
        it.load_failed = ($urandom_range(0, 3) == 0);
        if (r < 3) it.opcode = OP_NONE;
        else if (r < 13) it.opcode = OP_PIN;
        else if (r < 25) it.opcode = OP_BATCH;
        else it.opcode = OP_LOOKUP;
        if ($urandom_range(0, 9) == 0) it.expert = 8'($urandom_range(0, 255));
        else it.expert = 8'($urandom_range(0, pool - 1));
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.note_input(it);
        items_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        release_input();
        while (tracker.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_reg(idx, val);
    endtask

    task automatic set_config(int e, int s);
        drain();
        repeat (HOLD_OFF) @(posedge i_clk);
        write_reg(CFG_EXPERTS_IN_USE, 9'(e));
        write_reg(CFG_SLOTS_IN_USE, 9'(s));
        cur_exp = e;
        cur_slt = s;
        configs++;
    endtask

    task automatic run_random(int count);
        int done;
        int iter;
        int pool;
        int n_exp;
        int n_slt;
        t_in_item it;
        n_exp = (cur_exp > NUM_EXPERTS_DEF) ? NUM_EXPERTS_DEF : cur_exp;
        n_slt = (cur_slt > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : cur_slt;
        pool  = 2 * n_slt + 3;
        if (n_exp > 0 && pool > n_exp) pool = n_exp;
        done = 0;
        iter = 0;
        while (done < count) begin
            if (iter % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            // sender holds off until every result is back
            if (iter % 150 == 149) drain();
            it = rand_item(pool);
            send_item(it);
            if (it.opcode != OP_NONE) done++;
            iter++;
        end
    endtask

    initial begin
        int ph_exp[8];
        int ph_slt[8];
        int ph_cnt[8];
        int p;
        ph_exp = '{256, 1, 511, 0, 256, 100, 255, 256};
        ph_slt = '{1, 1, 63, 5, 0, 8, 17, 32};
        ph_cnt = '{200, 100, 250, 60, 80, 300, 250, 300};
        tracker = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // opening sequence at reset settings
        send_item(mk(OP_LOOKUP, 0, 0, 0));
        send_item(mk(OP_LOOKUP, 0, 1, 1));
        send_item(mk(OP_LOOKUP, 255, 1, 1));
        send_item(mk(OP_PIN, 255, 1, 0));
        send_item(mk(OP_PIN, 0, 0, 1));
        send_item(mk(OP_NONE, 170, 1, 1));
        send_item(mk(OP_BATCH, 85, 1, 0));
        send_item(mk(OP_LOOKUP, 0, 0, 0));
        send_item(mk(OP_LOOKUP, 7, 0, 0));
        send_item(mk(OP_BATCH, 0, 0, 1));
        send_item(mk(OP_LOOKUP, 7, 0, 0));
        send_item(mk(OP_LOOKUP, 255, 0, 0));
        send_item(mk(OP_BATCH, 255, 0, 0));
        send_item(mk(OP_PIN, 255, 0, 0));
        run_random(250);

        // two slots: full table, invalid ids and lru eviction
        set_config(16, 2);
        send_item(mk(OP_LOOKUP, 1, 0, 0));
        send_item(mk(OP_LOOKUP, 2, 0, 0));
        send_item(mk(OP_LOOKUP, 3, 0, 0));
        send_item(mk(OP_LOOKUP, 20, 0, 0));
        send_item(mk(OP_PIN, 20, 1, 0));
        send_item(mk(OP_BATCH, 0, 0, 0));
        send_item(mk(OP_LOOKUP, 3, 0, 0));
        send_item(mk(OP_LOOKUP, 1, 0, 0));
        send_item(mk(OP_LOOKUP, 2, 0, 0));
        send_item(mk(OP_BATCH, 0, 0, 0));
        run_random(200);

        for (p = 0; p < 8; p++) begin
            set_config(ph_exp[p], ph_slt[p]);
            run_random(ph_cnt[p]);
        end

        drain();
        repeat (HOLD_OFF) @(posedge i_clk);
        $display("run covered %0d items and %0d results over %0d register settings",
                 items_sent, tracker.checked, configs);
        $display("hits %0d, misses %0d, duplicates %0d, invalid %0d, no slot %0d, errors %0d",
                 tracker.status_seen[RS_HIT], tracker.status_seen[RS_MISS],
                 tracker.status_seen[RS_DUP], tracker.status_seen[RS_INVALID],
                 tracker.status_seen[RS_NO_SLOT], tracker.errors);
        if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
            $display("expert_slot_lru_cache_top: match");
        end else begin
            $display("expert_slot_lru_cache_top: mismatch");
        end
        $finish;
    end

endmodule
